/* rtl/phm_pkg.sv */
// ============================================================================
// phm_pkg
// Shared types and constants for the peak-hold meter with accelerating decay.
// ============================================================================
package phm_pkg;

    // Fixed field widths
    localparam int LEVEL_W     = 18;
    localparam int HOLD_W      = 16;
    localparam int BASE_W      = 24;
    localparam int GROWTH_W    = 20;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Default sizes of the internal counter and decay step
    localparam int HOLD_COUNT_BITS_DEF = 16;
    localparam int STEP_BITS_DEF       = 32;

    // Hold time that disables decay, and fraction bits of the step below 1/1024 dB
    localparam logic [HOLD_W-1:0] HOLD_FOREVER    = 16'hFFFF;
    localparam int                STEP_FRAC_SHIFT = 8;

    // Register reset values
    localparam logic signed [LEVEL_W-1:0] FLOOR_RST     = -18'sd49152;
    localparam logic signed [LEVEL_W-1:0] CEILING_RST   = 18'sd12288;
    localparam logic signed [LEVEL_W-1:0] THRESHOLD_RST = 18'sd0;
    localparam logic [HOLD_W-1:0]         HOLD_RST      = 16'd30;
    localparam logic [BASE_W-1:0]         BASE_RST      = 24'd13107;
    localparam logic [GROWTH_W-1:0]       GROWTH_RST    = 20'd655;

    // Input command codes
    localparam logic CMD_LEVEL = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FLOOR     = 3'd0,
        REG_CEILING   = 3'd1,
        REG_THRESHOLD = 3'd2,
        REG_HOLD      = 3'd3,
        REG_BASE      = 3'd4,
        REG_GROWTH    = 3'd5
    } cfg_reg_t;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        logic signed [LEVEL_W-1:0] floor_level;
        logic signed [LEVEL_W-1:0] ceiling_level;
        logic signed [LEVEL_W-1:0] threshold_level;
        logic [HOLD_W-1:0]         hold_ticks;
        logic [BASE_W-1:0]         decay_base;
        logic [GROWTH_W-1:0]       decay_growth;
    } cfg_t;

endpackage

/* rtl/peak_hold_accelerating_decay_meter_unit.sv */
// ============================================================================
// peak_hold_accelerating_decay_meter_unit
// Level meter ballistics: peak capture, hold for a number of frame ticks,
// then an accelerating decay toward the floor.
// ============================================================================
//
//   channel   direction  handshake             payload
//   -------   ---------  --------------------  ---------------------------------
//   input     in         in_valid / in_stall   command, level_in
//   output    out        out_valid / out_stall level_out, over_threshold, decaying
//   config    in         cfg_we                cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low; an input transfer
// reaches the output through the input register, then the result register
// after the state update.
// The meter state updates as an item moves between the two registers.
// Reset (rst_n low, asynchronous) restores the configuration registers to
// their defaults, clears the tick count and empties both pipeline registers.
// A stalled output holds its result; the input register then fills and
// in_stall rises, without loss or repetition.
//
module peak_hold_accelerating_decay_meter_unit #(
    parameter int HOLD_COUNT_BITS = phm_pkg::HOLD_COUNT_BITS_DEF,
    parameter int STEP_BITS       = phm_pkg::STEP_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic signed [phm_pkg::LEVEL_W-1:0] level_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [phm_pkg::LEVEL_W-1:0] level_out,
    output logic                               over_threshold,
    output logic                               decaying,
    input  logic                               cfg_we,
    input  logic [phm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [phm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import phm_pkg::*;

    cfg_t cfg;

    logic                      s1_valid_reg;
    logic                      s1_command_reg;
    logic signed [LEVEL_W-1:0] s1_level_reg;
    logic                      out_valid_reg;
    logic signed [LEVEL_W-1:0] level_out_reg;
    logic                      over_reg;
    logic                      decaying_reg;

    logic                      s1_advance;
    logic                      in_take;
    logic signed [LEVEL_W-1:0] res_level;
    logic                      res_over;
    logic                      res_decaying;

    phm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    phm_core #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS),
        .STEP_BITS       (STEP_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .advance      (s1_advance),
        .command      (s1_command_reg),
        .level_in     (s1_level_reg),
        .res_level    (res_level),
        .res_over     (res_over),
        .res_decaying (res_decaying)
    );

    // Advance the input stage when the result register is free or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_take    = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_advance)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_command_reg <= command;
            s1_level_reg   <= level_in;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= s1_advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            level_out_reg <= res_level;
            over_reg      <= res_over;
            decaying_reg  <= res_decaying;
        end
    end

    assign out_valid      = out_valid_reg;
    assign level_out      = level_out_reg;
    assign over_threshold = over_reg;
    assign decaying       = decaying_reg;

endmodule

/* rtl/phm_cfg.sv */
// ============================================================================
// phm_cfg
// Configuration register file written through a plain write port.
// ============================================================================
module phm_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [phm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [phm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output phm_pkg::cfg_t                      cfg
);
    import phm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave the registers alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FLOOR:     cfg_next.floor_level     = signed'(cfg_data[LEVEL_W-1:0]);
                REG_CEILING:   cfg_next.ceiling_level   = signed'(cfg_data[LEVEL_W-1:0]);
                REG_THRESHOLD: cfg_next.threshold_level = signed'(cfg_data[LEVEL_W-1:0]);
                REG_HOLD:      cfg_next.hold_ticks      = cfg_data[HOLD_W-1:0];
                REG_BASE:      cfg_next.decay_base      = cfg_data[BASE_W-1:0];
                REG_GROWTH:    cfg_next.decay_growth    = cfg_data[GROWTH_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.floor_level     <= FLOOR_RST;
            cfg_reg.ceiling_level   <= CEILING_RST;
            cfg_reg.threshold_level <= THRESHOLD_RST;
            cfg_reg.hold_ticks      <= HOLD_RST;
            cfg_reg.decay_base      <= BASE_RST;
            cfg_reg.decay_growth    <= GROWTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/phm_core.sv */
// ============================================================================
// phm_core
// Meter state (level, tick count, decay step) and its single-pass update.
// ============================================================================
module phm_core #(
    parameter int HOLD_COUNT_BITS = phm_pkg::HOLD_COUNT_BITS_DEF,
    parameter int STEP_BITS       = phm_pkg::STEP_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  phm_pkg::cfg_t                      cfg,
    input  logic                               advance,
    input  logic                               command,
    input  logic signed [phm_pkg::LEVEL_W-1:0] level_in,
    output logic signed [phm_pkg::LEVEL_W-1:0] res_level,
    output logic                               res_over,
    output logic                               res_decaying
);
    import phm_pkg::*;

    localparam int AMT_W = STEP_BITS - STEP_FRAC_SHIFT;
    localparam int DIF_W = ((AMT_W > LEVEL_W) ? AMT_W : LEVEL_W) + 2;
    localparam int BSE_W = (STEP_BITS > BASE_W) ? STEP_BITS : BASE_W;
    localparam int GRW_W = ((STEP_BITS > GROWTH_W) ? STEP_BITS : GROWTH_W) + 1;
    localparam int CNT_W = (HOLD_COUNT_BITS > HOLD_W) ? HOLD_COUNT_BITS : HOLD_W;
    localparam logic [STEP_BITS-1:0]       STEP_MAX = {STEP_BITS{1'b1}};
    localparam logic [HOLD_COUNT_BITS-1:0] CNT_MAX  = {HOLD_COUNT_BITS{1'b1}};

    logic signed [LEVEL_W-1:0]  display_reg;
    logic signed [LEVEL_W-1:0]  display_next;
    logic [HOLD_COUNT_BITS-1:0] count_reg;
    logic [HOLD_COUNT_BITS-1:0] count_next;
    logic [STEP_BITS-1:0]       step_reg;
    logic [STEP_BITS-1:0]       step_next;

    logic signed [LEVEL_W-1:0]  sample_lo;
    logic signed [LEVEL_W-1:0]  sample_clamped;
    logic [STEP_BITS-1:0]       base_sat;
    logic [HOLD_COUNT_BITS-1:0] count_inc;
    logic                       decay_now;
    logic [AMT_W-1:0]           amount;
    logic signed [DIF_W-1:0]    diff;
    logic signed [DIF_W-1:0]    diff_lo;
    logic signed [DIF_W-1:0]    diff_clamped;
    logic signed [LEVEL_W-1:0]  decayed;
    logic [GRW_W-1:0]           grown;
    logic [STEP_BITS-1:0]       step_grown;

    // Clamp the sample: floor first, then ceiling
    always_comb
    begin
        sample_lo      = (level_in < cfg.floor_level) ? cfg.floor_level : level_in;
        sample_clamped = (sample_lo > cfg.ceiling_level) ? cfg.ceiling_level : sample_lo;
    end

    // Saturate the configured base step to the step width
    assign base_sat = (BSE_W'(cfg.decay_base) > BSE_W'(STEP_MAX))
                      ? STEP_MAX : STEP_BITS'(cfg.decay_base);

    // Advance the tick count, saturating
    assign count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign decay_now = (cfg.hold_ticks != HOLD_FOREVER)
                       && (CNT_W'(count_inc) > CNT_W'(cfg.hold_ticks));

    // Drop the level by the whole part of the step and clamp
    always_comb
    begin
        amount       = step_reg[STEP_BITS-1:STEP_FRAC_SHIFT];
        diff         = DIF_W'(display_reg) - DIF_W'(signed'({1'b0, amount}));
        diff_lo      = (diff < DIF_W'(cfg.floor_level)) ? DIF_W'(cfg.floor_level) : diff;
        diff_clamped = (diff_lo > DIF_W'(cfg.ceiling_level))
                       ? DIF_W'(cfg.ceiling_level) : diff_lo;
        decayed      = LEVEL_W'(diff_clamped);
    end

    // Grow the step, saturating
    always_comb
    begin
        grown      = GRW_W'(step_reg) + GRW_W'(cfg.decay_growth);
        step_grown = (grown > GRW_W'(STEP_MAX)) ? STEP_MAX : STEP_BITS'(grown);
    end

    // Select the next state for the current item
    always_comb
    begin
        display_next = display_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        if (command == CMD_LEVEL)
        begin
            if ((sample_clamped > display_reg) || (sample_clamped == cfg.floor_level))
            begin
                display_next = sample_clamped;
                count_next   = '0;
                step_next    = base_sat;
            end
        end
        else
        begin
            count_next = count_inc;
            if (decay_now)
            begin
                display_next = decayed;
                step_next    = (decayed <= cfg.floor_level) ? base_sat : step_grown;
            end
        end
    end

    // Result fields from the updated state
    assign res_level    = display_next;
    assign res_over     = display_next > cfg.threshold_level;
    assign res_decaying = (cfg.hold_ticks != HOLD_FOREVER)
                          && (CNT_W'(count_next) > CNT_W'(cfg.hold_ticks));

    // Hold the meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_reg <= FLOOR_RST;
            count_reg   <= '0;
            step_reg    <= (BSE_W'(BASE_RST) > BSE_W'(STEP_MAX))
                           ? STEP_MAX : STEP_BITS'(BASE_RST);
        end
        else if (advance)
        begin
            display_reg <= display_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
        end
    end

endmodule

/* rtl/phm_checker.sv */
// ============================================================================
// phm_checker
// Port-level checks of the meter's pipeline and handshake behavior.
// ============================================================================
module phm_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [phm_pkg::LEVEL_W-1:0] level_out,
    input  logic                               over_threshold,
    input  logic                               decaying
);
    import phm_pkg::*;

    // Stall the input only while a result is held at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output");

    // A new result follows an input transfer through the input and result registers
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without a matching input transfer");

    // A held result keeps its payload
    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(level_out) && $stable(over_threshold)
             && $stable(decaying)))
        else $error("stalled result changed");

endmodule

bind peak_hold_accelerating_decay_meter_unit phm_checker u_phm_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the peak-hold meter with accelerating decay.
// A queue-fed driver offers level samples and frame ticks with random gaps.
// A clocked monitor compares every output transfer with a software copy of
// the meter's ballistics. Register settings change between phases, only
// once the block has drained.
// ============================================================================
module tb_top;
    import phm_pkg::*;

    localparam int MAX_GAP          = 12;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 90;
    localparam int PRESSURE_PHASE   = 4;
    localparam int TIGHT_PHASE      = 7;
    localparam int MAX_REPORTS      = 30;

    // Indexes past the register list; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [STEP_BITS_DEF-1:0]       STEP_MAX  = '1;
    localparam logic [HOLD_COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                      cmd;
        logic signed [LEVEL_W-1:0] level;
    } meter_item_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      over;
        logic                      decay;
    } meter_result_t;

    // DUT connections; the inputs driven by the bench are known from time zero
    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      in_valid       = 1'b0;
    logic                      in_stall;
    logic                      command        = CMD_LEVEL;
    logic signed [LEVEL_W-1:0] level_in       = '0;
    logic                      out_valid;
    logic                      out_stall      = 1'b0;
    logic signed [LEVEL_W-1:0] level_out;
    logic                      over_threshold;
    logic                      decaying;
    logic                      cfg_we         = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index      = '0;
    logic [CFG_DATA_W-1:0]     cfg_data       = '0;

    // Meter copy: settings and ballistics state
    cfg_t                           meter_cfg;
    longint                         shown_level;
    logic [HOLD_COUNT_BITS_DEF-1:0] ticks_held;
    logic [STEP_BITS_DEF-1:0]       fall_step;

    meter_item_t   pending_items[$];
    meter_result_t expected_results[$];
    meter_item_t   next_item;
    meter_result_t oldest_result;

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned setting_count   = 0;
    int unsigned peaks_captured  = 0;
    int unsigned decay_results   = 0;
    int unsigned over_results    = 0;

    int gap_left       = 0;
    int stall_left     = 0;
    int long_hold_left = 0;
    int quiet_cycles   = 0;

    logic tx_tight        = 1'b0;
    logic rx_tight        = 1'b0;
    logic rx_hold_pending = 1'b0;

    peak_hold_accelerating_decay_meter_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .level_in       (level_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .level_out      (level_out),
        .over_threshold (over_threshold),
        .decaying       (decaying),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint floor_lv();
        return longint'($signed(meter_cfg.floor_level));
    endfunction

    function automatic longint ceil_lv();
        return longint'($signed(meter_cfg.ceiling_level));
    endfunction

    function automatic longint thr_lv();
        return longint'($signed(meter_cfg.threshold_level));
    endfunction

    // Lower bound first, then upper: an inverted range lands on the ceiling
    function automatic longint clamp_level(input longint v);
        longint r;
        r = v;
        if (r < floor_lv())
            r = floor_lv();
        if (r > ceil_lv())
            r = ceil_lv();
        return r;
    endfunction

    function automatic logic hold_expired();
        return meter_cfg.hold_ticks != HOLD_FOREVER && ticks_held > meter_cfg.hold_ticks;
    endfunction

    // Advance the meter by one accepted item and queue the display it produces
    task automatic advance_meter(input logic cmd, input logic signed [LEVEL_W-1:0] lvl);
        longint        v;
        longint        grown;
        meter_result_t res;
        if (cmd == CMD_LEVEL)
        begin
            v = clamp_level(longint'(lvl));
            if (v > shown_level || v == floor_lv())
            begin
                shown_level = v;
                ticks_held  = '0;
                fall_step   = meter_cfg.decay_base;
                peaks_captured++;
            end
        end
        else
        begin
            if (ticks_held != COUNT_MAX)
                ticks_held++;
            if (hold_expired())
            begin
                shown_level = clamp_level(shown_level - longint'(fall_step >> STEP_FRAC_SHIFT));
                grown = longint'(fall_step) + longint'(meter_cfg.decay_growth);
                if (grown > longint'(STEP_MAX))
                    fall_step = STEP_MAX;
                else
                    fall_step = fall_step + meter_cfg.decay_growth;
                if (shown_level <= floor_lv())
                    fall_step = meter_cfg.decay_base;
            end
        end
        res.level = shown_level[LEVEL_W-1:0];
        res.over  = shown_level > thr_lv();
        res.decay = hold_expired();
        expected_results = {expected_results, res};
    endtask

    task automatic report_mismatch(input string what, input logic signed [63:0] want,
                                   input logic signed [63:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s expected %0d, got %0d",
                     $time, results_checked, what, want, got);
    endtask

    task automatic queue_item(input logic cmd, input longint lvl);
        meter_item_t it;
        it.cmd   = cmd;
        it.level = lvl[LEVEL_W-1:0];
        pending_items = {pending_items, it};
    endtask

    // Keep the register bits and fill the unused upper data bits with noise
    function automatic logic [CFG_DATA_W-1:0] with_junk(input longint v, input int w);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] d;
        keep = (CFG_DATA_W'(1) << w) - 1'b1;
        d    = CFG_DATA_W'($urandom);
        return (d & ~keep) | (CFG_DATA_W'(v) & keep);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        reg_writes++;
        case (idx)
            REG_FLOOR:     meter_cfg.floor_level     = data[LEVEL_W-1:0];
            REG_CEILING:   meter_cfg.ceiling_level   = data[LEVEL_W-1:0];
            REG_THRESHOLD: meter_cfg.threshold_level = data[LEVEL_W-1:0];
            REG_HOLD:      meter_cfg.hold_ticks      = data[HOLD_W-1:0];
            REG_BASE:      meter_cfg.decay_base      = data[BASE_W-1:0];
            REG_GROWTH:    meter_cfg.decay_growth    = data[GROWTH_W-1:0];
            default:       ;
        endcase
    endtask

    // Write every register, then both spare indexes, and return at a falling edge
    task automatic apply_settings(input longint fl, input longint ce, input longint th,
                                  input int unsigned hold, input int unsigned base,
                                  input int unsigned growth);
        write_reg(REG_FLOOR,     with_junk(fl, LEVEL_W));
        write_reg(REG_CEILING,   with_junk(ce, LEVEL_W));
        write_reg(REG_THRESHOLD, with_junk(th, LEVEL_W));
        write_reg(REG_HOLD,      with_junk(hold, HOLD_W));
        write_reg(REG_BASE,      with_junk(base, BASE_W));
        write_reg(REG_GROWTH,    with_junk(growth, GROWTH_W));
        write_reg(REG_SPARE_LO,  CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI,  CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        setting_count++;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Mostly tick runs of 1 to 24 ticks between level samples, plus floor and random levels
    task automatic fill_random(input int count);
        int     left;
        int     pick;
        int     burst;
        longint lo;
        longint hi;
        left = count;
        while (left > 0)
        begin
            lo   = floor_lv();
            hi   = ceil_lv();
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                queue_item(CMD_LEVEL, longint'($urandom));
                left--;
            end
            else if (pick == 1)
            begin
                if ($urandom_range(0, 2) == 0)
                    queue_item(CMD_LEVEL, lo - longint'($urandom_range(0, lo + 131072)));
                else
                    queue_item(CMD_LEVEL, lo);
                left--;
            end
            else if (pick <= 3)
            begin
                if (lo <= hi)
                    queue_item(CMD_LEVEL, lo + longint'($urandom_range(0, hi - lo)));
                else
                    queue_item(CMD_LEVEL, longint'($urandom));
                left--;
            end
            else
            begin
                burst = $urandom_range(1, 24);
                if (burst > left)
                    burst = left;
                repeat (burst) queue_item(CMD_TICK, longint'($urandom));
                left -= burst;
            end
        end
    endtask

    // Driver: hold a stalled transfer, otherwise idle out the gap or launch the next item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_meter(command, level_in);
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    command  <= next_item.cmd;
                    level_in <= next_item.level;
                    gap_left = tx_tight ? 0 : $urandom_range(0, MAX_GAP);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: draw a stall per result; a requested long hold takes priority
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left     = 0;
            long_hold_left = 0;
        end
        else
        begin
            if (rx_hold_pending)
            begin
                long_hold_left  = LONG_HOLD_CYCLES;
                rx_hold_pending = 1'b0;
            end
            if (out_valid && !out_stall)
                stall_left = rx_tight ? 0 : $urandom_range(0, MAX_GAP);
            if (long_hold_left != 0)
            begin
                long_hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Monitor: compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected, level_out", 0, level_out);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (level_out !== oldest_result.level)
                    report_mismatch("level_out", $signed(oldest_result.level), level_out);
                if (over_threshold !== oldest_result.over)
                    report_mismatch("over_threshold", oldest_result.over, over_threshold);
                if (decaying !== oldest_result.decay)
                    report_mismatch("decaying", oldest_result.decay, decaying);
                if (oldest_result.decay)
                    decay_results++;
                if (oldest_result.over)
                    over_results++;
                results_checked++;
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        longint      fl;
        longint      ce;
        longint      th;
        longint      swap;
        int unsigned hold;
        int unsigned base;
        int unsigned growth;
        int          phase;

        meter_cfg   = '{FLOOR_RST, CEILING_RST, THRESHOLD_RST, HOLD_RST, BASE_RST, GROWTH_RST};
        shown_level = longint'(FLOOR_RST);
        ticks_held  = '0;
        fall_step   = BASE_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short hold: clamping at both ends, capture rules, decay past the hold
        apply_settings(-20000, 20000, 1000, 2, 24'h00C000, 20'h10000);
        queue_item(CMD_LEVEL, 131071);
        queue_item(CMD_LEVEL, -131072);
        queue_item(CMD_LEVEL, 1500);
        queue_item(CMD_LEVEL, 1000);
        repeat (5) queue_item(CMD_TICK, longint'($urandom));
        queue_item(CMD_LEVEL, -20000);
        queue_item(CMD_TICK, -1);
        wait_drained();

        // Floor above ceiling, no hold, largest step and growth
        apply_settings(5000, -5000, -131072, 0, 24'hFFFFFF, 20'hFFFFF);
        queue_item(CMD_LEVEL, 0);
        queue_item(CMD_TICK, 0);
        queue_item(CMD_LEVEL, 131071);
        queue_item(CMD_TICK, 131071);
        wait_drained();

        // Hold forever: ticks never start a decay
        apply_settings(-131072, 131071, -131072, HOLD_FOREVER, 0, 0);
        queue_item(CMD_LEVEL, 131071);
        repeat (4) queue_item(CMD_TICK, longint'($urandom));
        queue_item(CMD_LEVEL, -131072);
        wait_drained();

        // Random phases, each under fresh settings
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            if (phase == 0)
            begin
                fl = -131072;  ce = 131071;   th = 131071;
                hold = 0;      base = 24'hFFFFFF; growth = 20'hFFFFF;
            end
            else if (phase == 1)
            begin
                fl = 131071;   ce = -131072;  th = -131072;
                hold = 0;      base = 0;      growth = 0;
            end
            else
            begin
                fl = -131072 + longint'($urandom_range(0, 100000));
                ce = longint'($urandom_range(0, 131071));
                if ($urandom_range(0, 5) == 0)
                begin
                    swap = fl;
                    fl   = ce;
                    ce   = swap;
                end
                if (fl < ce)
                    th = fl + longint'($urandom_range(0, ce - fl));
                else
                    th = longint'($urandom_range(0, 262143)) - 131072;
                hold   = ($urandom_range(0, 7) == 0) ? HOLD_FOREVER : $urandom_range(0, 12);
                base   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                     : $urandom_range(0, 200000);
                growth = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                     : $urandom_range(0, 60000);
            end
            apply_settings(fl, ce, th, hold, base, growth);
            tx_tight = (phase == PRESSURE_PHASE) || (phase == TIGHT_PHASE);
            rx_tight = (phase == TIGHT_PHASE);
            // Back up the output while the sender keeps offering items
            if (phase == PRESSURE_PHASE)
                rx_hold_pending = 1'b1;
            fill_random(ITEMS_PER_PHASE);
        end

        // Drain, then allow the pipeline latency for stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered, count", expected_results.size(), 0);

        $display("Run covered %0d items under %0d register settings (%0d writes), %0d peaks taken.",
                 items_sent, setting_count, reg_writes, peaks_captured);
        $display("Checked %0d results: %0d decaying, %0d over threshold, %0d mismatches.",
                 results_checked, decay_results, over_results, error_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
